/* rtl/direction_cone_pair_filter_top_assert.svh */
`ifndef DIRECTION_CONE_PAIR_FILTER_TOP_ASSERT_SVH
`define DIRECTION_CONE_PAIR_FILTER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define DCPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DCPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dcpf_pkg.sv */
package dcpf_pkg;

  typedef enum logic [2:0] {
    REG_UNRESTRICTED = 3'd0,
    REG_HORIZ_DIR_X  = 3'd1,
    REG_HORIZ_DIR_Y  = 3'd2,
    REG_VERT_DIR_XY  = 3'd3,
    REG_VERT_DIR_Z   = 3'd4,
    REG_COS_TOL_H    = 3'd5,
    REG_COS_TOL_V    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic v_unr;
    logic h_unr;
    logic all_dir;
  } unr_flags_t;

endpackage

/* rtl/dcpf_if.sv */
interface dcpf_in_if #(parameter int COORD_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] az;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by;
  logic signed [COORD_WIDTH-1:0] bz;
  logic                          symmetric;
  modport source (output valid, ax, ay, az, bx, by, bz, symmetric, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, symmetric, output ready);
endinterface

interface dcpf_out_if #(parameter int COORD_WIDTH = 24);
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [COORD_WIDTH:0] distance;
  modport source (output valid, accepted, distance, input ready);
  modport sink (input valid, accepted, distance, output ready);
endinterface

/* rtl/dcpf_front.sv */
module dcpf_front import dcpf_pkg::*; #(
  parameter int CW = 24,
  parameter int KW = 16,
  localparam int DW = CW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [CW-1:0]  ax,
  input  logic signed [CW-1:0]  ay,
  input  logic signed [CW-1:0]  az,
  input  logic signed [CW-1:0]  bx,
  input  logic signed [CW-1:0]  by,
  input  logic signed [CW-1:0]  bz,
  input  logic                  sym,
  input  logic signed [KW-1:0]  hdx,
  input  logic signed [KW-1:0]  hdy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2*DW-1:0]       sxy,
  output logic [2*DW-1:0]       sall,
  output logic signed [DW+KW:0] dot_h,
  output logic signed [DW-1:0]  pz,
  output logic                  sym_o,
  output logic                  xy_zero,
  output logic                  pz_zero
);

  logic [2:0] v_r;
  logic [2:0] en;

  logic signed [DW-1:0] px0_r, py0_r, pz0_r;
  logic                 sym0_r;

  logic [2*DW-1:0]         sqx1_r, sqy1_r, sqz1_r;
  logic signed [DW+KW-1:0] hx1_r, hy1_r;
  logic signed [DW-1:0]    pz1_r;
  logic                    sym1_r, xyz1_r, pzz1_r;

  logic [2*DW-1:0]       sxy2_r, sall2_r;
  logic signed [DW+KW:0] doth2_r;
  logic signed [DW-1:0]  pz2_r;
  logic                  sym2_r, xyz2_r, pzz2_r;

  assign en[2]    = !v_r[2] || out_ready;
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px0_r  <= DW'(ax) - DW'(bx);
      py0_r  <= DW'(ay) - DW'(by);
      pz0_r  <= DW'(az) - DW'(bz);
      sym0_r <= sym;
    end
    if (en[1]) begin
      sqx1_r <= unsigned'((2*DW)'(px0_r) * (2*DW)'(px0_r));
      sqy1_r <= unsigned'((2*DW)'(py0_r) * (2*DW)'(py0_r));
      sqz1_r <= unsigned'((2*DW)'(pz0_r) * (2*DW)'(pz0_r));
      hx1_r  <= (DW+KW)'(px0_r) * (DW+KW)'(hdx);
      hy1_r  <= (DW+KW)'(py0_r) * (DW+KW)'(hdy);
      pz1_r  <= pz0_r;
      sym1_r <= sym0_r;
      xyz1_r <= (px0_r == '0) && (py0_r == '0);
      pzz1_r <= (pz0_r == '0);
    end
    if (en[2]) begin
      sxy2_r  <= sqx1_r + sqy1_r;
      sall2_r <= sqx1_r + sqy1_r + sqz1_r;
      doth2_r <= (DW+KW+1)'(hx1_r) + (DW+KW+1)'(hy1_r);
      pz2_r   <= pz1_r;
      sym2_r  <= sym1_r;
      xyz2_r  <= xyz1_r;
      pzz2_r  <= pzz1_r;
    end
  end

  assign out_valid = v_r[2];
  assign sxy       = sxy2_r;
  assign sall      = sall2_r;
  assign dot_h     = doth2_r;
  assign pz        = pz2_r;
  assign sym_o     = sym2_r;
  assign xy_zero   = xyz2_r;
  assign pz_zero   = pzz2_r;

endmodule

/* rtl/dcpf_sqrt.sv */
module dcpf_sqrt import dcpf_pkg::*; #(
  parameter int DW = 25,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2*DW-1:0] na,
  input  logic [2*DW-1:0] nb,
  input  logic [SW-1:0]   side_i,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [DW-1:0]   root_a,
  output logic [DW-1:0]   root_b,
  output logic [SW-1:0]   side_o
);

  localparam int RMW = DW + 2;

  logic [DW-1:0]   v_r;
  logic [DW:0]     en;
  logic [2*DW-1:0] na_r [DW];
  logic [2*DW-1:0] nb_r [DW];
  logic [RMW-1:0]  ra_r [DW];
  logic [RMW-1:0]  rb_r [DW];
  logic [DW-1:0]   qa_r [DW];
  logic [DW-1:0]   qb_r [DW];
  logic [SW-1:0]   sd_r [DW];

  assign en[DW]   = out_ready;
  assign in_ready = en[0];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic            vin;
    logic [2*DW-1:0] nai, nbi;
    logic [RMW-1:0]  rai, rbi, ra_b, rb_b, trial_a, trial_b;
    logic [DW-1:0]   qai, qbi;
    logic [SW-1:0]   sdi;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign nai = na;
      assign nbi = nb;
      assign rai = '0;
      assign rbi = '0;
      assign qai = '0;
      assign qbi = '0;
      assign sdi = side_i;
    end else begin : g_next
      assign vin = v_r[k-1];
      assign nai = na_r[k-1];
      assign nbi = nb_r[k-1];
      assign rai = ra_r[k-1];
      assign rbi = rb_r[k-1];
      assign qai = qa_r[k-1];
      assign qbi = qb_r[k-1];
      assign sdi = sd_r[k-1];
    end

    assign en[k]   = !v_r[k] || en[k+1];
    assign ra_b    = {rai[RMW-3:0], nai[2*DW-1-2*k], nai[2*DW-2-2*k]};
    assign rb_b    = {rbi[RMW-3:0], nbi[2*DW-1-2*k], nbi[2*DW-2-2*k]};
    assign trial_a = {qai, 2'b01};
    assign trial_b = {qbi, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        na_r[k] <= nai;
        nb_r[k] <= nbi;
        sd_r[k] <= sdi;
        if (ra_b >= trial_a) begin
          ra_r[k] <= ra_b - trial_a;
          qa_r[k] <= {qai[DW-2:0], 1'b1};
        end else begin
          ra_r[k] <= ra_b;
          qa_r[k] <= {qai[DW-2:0], 1'b0};
        end
        if (rb_b >= trial_b) begin
          rb_r[k] <= rb_b - trial_b;
          qb_r[k] <= {qbi[DW-2:0], 1'b1};
        end else begin
          rb_r[k] <= rb_b;
          qb_r[k] <= {qbi[DW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign root_a    = qa_r[DW-1];
  assign root_b    = qb_r[DW-1];
  assign side_o    = sd_r[DW-1];

endmodule

/* rtl/dcpf_cone.sv */
module dcpf_cone import dcpf_pkg::*; #(
  parameter int DW = 25,
  parameter int KW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DW-1:0]         nxy,
  input  logic [DW-1:0]         dist_in,
  input  logic signed [DW+KW:0] dot_h,
  input  logic signed [DW-1:0]  pz,
  input  logic                  sym,
  input  logic                  xy_zero,
  input  logic                  pz_zero,
  input  unr_flags_t            flags,
  input  logic signed [KW-1:0]  vdxy,
  input  logic signed [KW-1:0]  vdz,
  input  logic signed [KW-1:0]  cos_h,
  input  logic signed [KW-1:0]  cos_v,
  dcpf_out_if.source            out_ch
);

  localparam int PW = DW + KW + 1;

  logic [1:0] v_r;
  logic [1:0] en;

  logic signed [PW-1:0] thh_r, pvx_r, thv_r, pvz_r;
  logic signed [DW+KW:0] doth_r;
  logic [DW-1:0]        dist1_r;
  logic                 sym_r, xyz_r, pzz_r;

  logic                 acc_r;
  logic [DW-1:0]        dist2_r;

  logic signed [PW:0]   dot_v;
  logic signed [PW+1:0] qh, qv;
  logic                 rej_h, rej_v, pass_all, ok;

  assign en[1]    = !v_r[1] || out_ch.ready;
  assign en[0]    = !v_r[0] || en[1];
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      thh_r   <= PW'(cos_h) * PW'(signed'({1'b0, nxy}));
      pvx_r   <= PW'(vdxy) * PW'(signed'({1'b0, nxy}));
      thv_r   <= PW'(cos_v) * PW'(signed'({1'b0, dist_in}));
      pvz_r   <= PW'(vdz) * PW'(pz);
      doth_r  <= dot_h;
      dist1_r <= dist_in;
      sym_r   <= sym;
      xyz_r   <= xy_zero;
      pzz_r   <= pz_zero;
    end
  end

  always_comb begin
    dot_v = (PW+1)'(pvx_r) + (PW+1)'(pvz_r);
    qh    = (sym_r && doth_r < 0) ? -(PW+2)'(doth_r) : (PW+2)'(doth_r);
    qv    = (sym_r && dot_v < 0) ? -(PW+2)'(dot_v) : (PW+2)'(dot_v);
    rej_h = !flags.h_unr && !xyz_r && (qh < (PW+2)'(thh_r));
    rej_v = !flags.v_unr && !(xyz_r && pzz_r) && (qv < (PW+2)'(thv_r));
    pass_all = flags.all_dir || (flags.h_unr && flags.v_unr) ||
               (flags.h_unr && pzz_r) || (flags.v_unr && xyz_r);
    ok    = pass_all || !(rej_h || rej_v);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      acc_r   <= ok;
      dist2_r <= dist1_r;
    end
  end

  assign out_ch.valid    = v_r[1];
  assign out_ch.accepted = acc_r;
  assign out_ch.distance = dist2_r;

endmodule

/* rtl/direction_cone_pair_filter_top.sv */
// Direction cone pair filter: takes one point pair per cycle and returns the truncated
// Euclidean distance and the cone test result. The pipeline has three front stages for
// difference, squares and sums, one stage per result bit of the digit-by-digit square
// root, and two stages for the cone compare. Throughput is one word per cycle; a stall
// on the output backs up only as far as there are no bubbles to absorb it. Write the
// configuration registers only while idle.
`include "direction_cone_pair_filter_top_assert.svh"

module direction_cone_pair_filter_top import dcpf_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int COS_WIDTH   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dcpf_in_if.sink              in_ch,
  dcpf_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [COS_WIDTH-1:0] cfg_data
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int KW = COS_WIDTH;
  localparam int SW = (DW + KW + 1) + DW + 3;
  localparam logic signed [KW-1:0] CosOne = KW'(1) <<< (KW - 2);

  unr_flags_t           flags_r;
  logic signed [KW-1:0] hdx_r, hdy_r, vdxy_r, vdz_r, cth_r, ctv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '{v_unr: 1'b0, h_unr: 1'b0, all_dir: 1'b1};
      hdx_r   <= '0;
      hdy_r   <= CosOne;
      vdxy_r  <= CosOne;
      vdz_r   <= '0;
      cth_r   <= -CosOne;
      ctv_r   <= -CosOne;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_UNRESTRICTED: flags_r <= unr_flags_t'(cfg_data[2:0]);
        REG_HORIZ_DIR_X:  hdx_r   <= cfg_data;
        REG_HORIZ_DIR_Y:  hdy_r   <= cfg_data;
        REG_VERT_DIR_XY:  vdxy_r  <= cfg_data;
        REG_VERT_DIR_Z:   vdz_r   <= cfg_data;
        REG_COS_TOL_H:    cth_r   <= cfg_data;
        REG_COS_TOL_V:    ctv_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                  f_valid, f_ready;
  logic [2*DW-1:0]       f_sxy, f_sall;
  logic signed [DW+KW:0] f_doth;
  logic signed [DW-1:0]  f_pz;
  logic                  f_sym, f_xyz, f_pzz;

  dcpf_front #(.CW(COORD_WIDTH), .KW(KW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .ax       (in_ch.ax),
    .ay       (in_ch.ay),
    .az       (in_ch.az),
    .bx       (in_ch.bx),
    .by       (in_ch.by),
    .bz       (in_ch.bz),
    .sym      (in_ch.symmetric),
    .hdx      (hdx_r),
    .hdy      (hdy_r),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .sxy      (f_sxy),
    .sall     (f_sall),
    .dot_h    (f_doth),
    .pz       (f_pz),
    .sym_o    (f_sym),
    .xy_zero  (f_xyz),
    .pz_zero  (f_pzz)
  );

  logic                  s_valid, s_ready;
  logic [DW-1:0]         s_nxy, s_dist;
  logic [SW-1:0]         s_side;
  logic signed [DW+KW:0] s_doth;
  logic signed [DW-1:0]  s_pz;
  logic                  s_sym, s_xyz, s_pzz;

  dcpf_sqrt #(.DW(DW), .SW(SW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .na       (f_sxy),
    .nb       (f_sall),
    .side_i   ({f_doth, f_pz, f_sym, f_xyz, f_pzz}),
    .out_valid(s_valid),
    .out_ready(s_ready),
    .root_a   (s_nxy),
    .root_b   (s_dist),
    .side_o   (s_side)
  );

  assign {s_doth, s_pz, s_sym, s_xyz, s_pzz} = s_side;

  dcpf_cone #(.DW(DW), .KW(KW)) u_cone (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s_valid),
    .in_ready (s_ready),
    .nxy      (s_nxy),
    .dist_in  (s_dist),
    .dot_h    (s_doth),
    .pz       (s_pz),
    .sym      (s_sym),
    .xy_zero  (s_xyz),
    .pz_zero  (s_pzz),
    .flags    (flags_r),
    .vdxy     (vdxy_r),
    .vdz      (vdz_r),
    .cos_h    (cth_r),
    .cos_v    (ctv_r),
    .out_ch   (out_ch)
  );

  // a stall can only come from a held output word
  `DCPF_ASSERT_NOW(a_stall_origin, !in_ch.ready, out_ch.valid && !out_ch.ready, "stall without held output")
  // a draining output frees the whole chain
  `DCPF_ASSERT_NOW(a_drain_frees, out_ch.valid && out_ch.ready, in_ch.ready, "input blocked while output drains")
  // a held output word stays valid
  `DCPF_ASSERT_NEXT(a_held_valid, out_ch.valid && !out_ch.ready, out_ch.valid, "output word dropped")

endmodule
